### src/riot_pkg.sv
// ----------------------------------------------------------------------------
// riot_pkg
// Shared types and constants for the interval timer and voice control ports.
// ----------------------------------------------------------------------------
package riot_pkg;

    localparam int unsigned OpW     = 2;
    localparam int unsigned OffsetW = 7;
    localparam int unsigned DataW   = 8;
    localparam int unsigned CountW  = 18;

    // operation codes of one input item
    typedef enum logic [OpW-1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // timer phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    // read decode on the low three offset bits
    localparam logic [2:0] RD_VOICE  = 3'd2;
    localparam logic [2:0] RD_CNT_A  = 3'd4;
    localparam logic [2:0] RD_FLAG_A = 3'd5;
    localparam logic [2:0] RD_CNT_B  = 3'd6;
    localparam logic [2:0] RD_FLAG_B = 3'd7;

    // write decode on the full offset
    localparam logic [OffsetW-1:0] WR_VOICE       = 7'h00;
    localparam logic [OffsetW-1:0] WR_TIMER_MASK  = 7'h74;
    localparam logic [OffsetW-1:0] WR_TIMER_MATCH = 7'h14;

    localparam logic [DataW-1:0]  FLAG_BYTE      = 8'h80;
    localparam logic [DataW-1:0]  ALL_ONES_BYTE  = 8'hFF;
    localparam logic [CountW-1:0] SECOND_PERIOD  = 18'h000FF;

    typedef struct packed {
        logic [OpW-1:0]     op;
        logic [OffsetW-1:0] offset;
        logic [DataW-1:0]   data;
    } item_t;

    typedef struct packed {
        logic [DataW-1:0] read_data;
        logic             irq_pulse;
        logic             reset_update;
        logic             reset_asserted;
    } result_t;

    // prescale 1, 8, 64, 1024 as a shift amount
    function automatic logic [3:0] prescale_shift(input logic [1:0] sel);
        logic [3:0] sh;
        case (sel)
            2'd0:    sh = 4'd0;
            2'd1:    sh = 4'd3;
            2'd2:    sh = 4'd6;
            default: sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

### src/riot_if.sv
// ----------------------------------------------------------------------------
// riot_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface riot_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [6:0] offset;
    logic [7:0] data;

    modport source (output valid, output op, output offset, output data, input ready);
    modport sink   (input valid, input op, input offset, input data, output ready);
endinterface

interface riot_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_pulse;
    logic       reset_update;
    logic       reset_asserted;

    modport source (output valid, output read_data, output irq_pulse,
                    output reset_update, output reset_asserted, input ready);
    modport sink   (input valid, input read_data, input irq_pulse,
                    input reset_update, input reset_asserted, output ready);
endinterface

### src/riot_timer_core.sv
// ----------------------------------------------------------------------------
// riot_timer_core
// Timer, flag and voice latch state with the per-item decode and result logic.
// ----------------------------------------------------------------------------
module riot_timer_core
    import riot_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    phase_t              phase_reg, phase_next;
    logic [CountW-1:0]   tick_count_reg, tick_count_next;
    logic [CountW-1:0]   period_reg, period_next;
    logic [1:0]          prescale_reg, prescale_next;
    logic                enable_irq_reg, enable_irq_next;
    logic                flag_reg, flag_next;
    logic                voice_msb_reg, voice_msb_next;

    logic [CountW-1:0]   count_inc;
    logic [3:0]          shift;
    logic [CountW-1:0]   elapsed_shifted;
    logic [DataW-1:0]    remain;
    logic [DataW-1:0]    remain_shifted;
    logic [CountW-1:0]   data_wide;

    // shared arithmetic
    always_comb
    begin
        count_inc       = tick_count_reg + 1'b1;
        shift           = prescale_shift(prescale_reg);
        elapsed_shifted = tick_count_reg >> shift;
        remain          = (tick_count_reg <= SECOND_PERIOD)
                          ? (ALL_ONES_BYTE - tick_count_reg[DataW-1:0]) : '0;
        remain_shifted  = remain >> shift;
        data_wide       = {{(CountW-DataW){1'b0}}, item.data};
    end

    // next state and result
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        period_next     = period_reg;
        prescale_next   = prescale_reg;
        enable_irq_next = enable_irq_reg;
        flag_next       = flag_reg;
        voice_msb_next  = voice_msb_reg;
        result          = '0;

        case (op_t'(item.op))
            OP_TICK:
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        tick_count_next = count_inc;
                        if (count_inc >= period_reg)
                        begin
                            flag_next        = 1'b1;
                            result.irq_pulse = enable_irq_reg;
                            phase_next       = PH_SECOND;
                            tick_count_next  = '0;
                            period_next      = SECOND_PERIOD;
                        end
                    end
                    PH_SECOND:
                    begin
                        tick_count_next = count_inc;
                        if (count_inc >= SECOND_PERIOD)
                        begin
                            phase_next      = PH_IDLE;
                            tick_count_next = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_WRITE:
            begin
                if (item.offset == WR_VOICE)
                begin
                    voice_msb_next        = item.data[7];
                    result.reset_update   = 1'b1;
                    result.reset_asserted = ~item.data[4];
                end
                else if ((item.offset & WR_TIMER_MASK) == WR_TIMER_MATCH)
                begin
                    enable_irq_next = item.offset[3];
                    prescale_next   = item.offset[1:0];
                    period_next     = data_wide << prescale_shift(item.offset[1:0]);
                    tick_count_next = '0;
                    phase_next      = PH_FIRST;
                end
            end
            OP_READ:
            begin
                case (item.offset[2:0])
                    RD_VOICE:
                    begin
                        result.read_data = {{(DataW-1){1'b0}}, voice_msb_reg};
                    end
                    RD_FLAG_A, RD_FLAG_B:
                    begin
                        result.read_data = flag_reg ? FLAG_BYTE : '0;
                        flag_next        = 1'b0;
                    end
                    RD_CNT_A, RD_CNT_B:
                    begin
                        flag_next = 1'b0;
                        case (phase_reg)
                            PH_FIRST:  result.read_data = elapsed_shifted[DataW-1:0];
                            PH_SECOND: result.read_data = remain_shifted;
                            default:   result.read_data = '0;
                        endcase
                    end
                    default:
                    begin
                        result.read_data = ALL_ONES_BYTE;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // state registers, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            period_reg     <= '0;
            prescale_reg   <= '0;
            enable_irq_reg <= 1'b0;
            flag_reg       <= 1'b0;
            voice_msb_reg  <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            period_reg     <= period_next;
            prescale_reg   <= prescale_next;
            enable_irq_reg <= enable_irq_next;
            flag_reg       <= flag_next;
            voice_msb_reg  <= voice_msb_next;
        end
    end

endmodule

### src/riot_interval_timer_ports_unit.sv
// ----------------------------------------------------------------------------
// riot_interval_timer_ports_unit
// Interval timer with expiry flag, interrupt pulse and voice control latch.
// ----------------------------------------------------------------------------
// Each input item is a base tick, a register write or a register read, and
// gives exactly one result. The unit accepts one item per clock while the
// result register is free or being taken. Each item is held in the input
// register, then the timer and decode logic update the counter and load
// the result register. A stalled result register holds the pipeline
// once the input register is also full.
module riot_interval_timer_ports_unit
    import riot_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    riot_in_if.sink    in_ch,
    riot_out_if.source out_ch
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t core_result;
    logic    advance;

    // item moves from input register to result register
    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg <= '{op: in_ch.op, offset: in_ch.offset, data: in_ch.data};
        end
    end

    riot_timer_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.read_data      = out_result_reg.read_data;
    assign out_ch.irq_pulse      = out_result_reg.irq_pulse;
    assign out_ch.reset_update   = out_result_reg.reset_update;
    assign out_ch.reset_asserted = out_result_reg.reset_asserted;

endmodule

### verif/riot_interval_timer_ports_unit_tb.sv
// ----------------------------------------------------------------------------
// riot_interval_timer_ports_unit_tb
// Self-checking bench for the interval timer and voice control ports. Ticks,
// register writes and register reads go in over a valid/ready channel. A
// predictor keeps its own copy of the timer, flag and latch state and queues
// one expected result per accepted item. Every result that comes out is
// checked field by field against the oldest entry. Directed tests cover the
// voice latch, decode, zero count, restart, each prescale and one long hold
// on the result side. They are followed by random timer sequences with
// random gaps on both sides.
// ----------------------------------------------------------------------------
module riot_interval_timer_ports_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import riot_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int ITEM_COUNT      = 1200;
    localparam int IDLE_RUN_MARGIN = 450;
    localparam int MAX_SHOWN       = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_CYCLES     = 250;

    // offsets that decode to nothing on a write
    localparam logic [OffsetW-1:0] OFF_EDGE    = 7'h07;
    localparam logic [OffsetW-1:0] OFF_SPARE_A = 7'h04;
    localparam logic [OffsetW-1:0] OFF_SPARE_B = 7'h34;
    localparam logic [OffsetW-1:0] OFF_TOP     = 7'h7F;

    // read decodes that fall to the all-ones default
    localparam logic [2:0] RD_SPARE_0 = 3'd0;
    localparam logic [2:0] RD_SPARE_1 = 3'd1;
    localparam logic [2:0] RD_SPARE_3 = 3'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    riot_in_if  in_bus ();
    riot_out_if out_bus ();

    riot_interval_timer_ports_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    always #4 clk = ~clk;

    // predicted timer state
    phase_t             tmr_phase;
    logic [CountW-1:0]  tmr_ticks;
    logic [CountW-1:0]  tmr_period;
    logic [1:0]         tmr_presc;
    logic               tmr_irq_en;
    logic               tmr_flag;
    logic [DataW-1:0]   voice_latch_q;
    logic [DataW-1:0]   edge_cfg;

    result_t exp_results [$];
    int      err_cnt     = 0;
    int      sent_cnt    = 0;
    int      idle_cycles = 0;
    int      hold_len    = 0;
    bit      src_idle_on = 1'b0;
    bit      snk_idle_on = 1'b0;

    // prescale 1, 8, 64, 1024 as a shift: 3 * sel, except 10 at the top
    function automatic logic [3:0] presc_bits(input logic [1:0] sel);
        logic [3:0] sh;
        sh = {1'b0, sel, 1'b0} + {2'b00, sel};
        if (sel == 2'd3)
            sh = 4'd10;
        return sh;
    endfunction

    function automatic logic [OffsetW-1:0] timer_offset(input logic irq, input logic [1:0] sel);
        return WR_TIMER_MATCH | {3'b000, irq, 1'b0, sel};
    endfunction

    // read offset with random upper bits, only bits 2:0 decode
    function automatic logic [OffsetW-1:0] read_offset(input logic [2:0] sel);
        logic [3:0] hi;
        hi = 4'($urandom_range(0, 15));
        return {hi, sel};
    endfunction

    task automatic timer_reset();
        tmr_phase     = PH_IDLE;
        tmr_ticks     = '0;
        tmr_period    = '0;
        tmr_presc     = 2'd0;
        tmr_irq_en    = 1'b0;
        tmr_flag      = 1'b0;
        voice_latch_q = ALL_ONES_BYTE;
        edge_cfg      = '0;
    endtask

    // advance the timer model by one item and return the result it gives
    function automatic result_t predict_timer(input item_t it);
        result_t           r;
        logic [CountW-1:0] left;
        r = '0;
        case (op_t'(it.op))
            OP_TICK:
            begin
                if (tmr_phase == PH_FIRST)
                begin
                    tmr_ticks = tmr_ticks + 1'b1;
                    if (tmr_ticks >= tmr_period)
                    begin
                        tmr_flag    = 1'b1;
                        r.irq_pulse = tmr_irq_en;
                        tmr_phase   = PH_SECOND;
                        tmr_ticks   = '0;
                        tmr_period  = SECOND_PERIOD;
                    end
                end
                else if (tmr_phase == PH_SECOND)
                begin
                    tmr_ticks = tmr_ticks + 1'b1;
                    if (tmr_ticks >= SECOND_PERIOD)
                    begin
                        tmr_phase = PH_IDLE;
                        tmr_ticks = '0;
                    end
                end
            end
            OP_WRITE:
            begin
                if (it.offset == WR_VOICE)
                begin
                    voice_latch_q    = it.data;
                    r.reset_update   = 1'b1;
                    r.reset_asserted = ~it.data[4];
                end
                else if (it.offset == OFF_EDGE)
                    edge_cfg = it.data;
                else if ((it.offset & WR_TIMER_MASK) == WR_TIMER_MATCH)
                begin
                    tmr_irq_en = it.offset[3];
                    tmr_presc  = it.offset[1:0];
                    tmr_period = {{(CountW-DataW){1'b0}}, it.data} << presc_bits(tmr_presc);
                    tmr_ticks  = '0;
                    tmr_phase  = PH_FIRST;
                end
            end
            OP_READ:
            begin
                case (it.offset[2:0])
                    RD_VOICE:
                        r.read_data = {7'b0, voice_latch_q[7]};
                    RD_FLAG_A, RD_FLAG_B:
                    begin
                        r.read_data = tmr_flag ? FLAG_BYTE : '0;
                        tmr_flag    = 1'b0;
                    end
                    RD_CNT_A, RD_CNT_B:
                    begin
                        tmr_flag = 1'b0;
                        if (tmr_phase == PH_FIRST)
                            left = tmr_ticks;
                        else if (tmr_phase == PH_SECOND)
                            left = (tmr_ticks <= SECOND_PERIOD) ? SECOND_PERIOD - tmr_ticks : '0;
                        else
                            left = '0;
                        left        = left >> presc_bits(tmr_presc);
                        r.read_data = left[DataW-1:0];
                    end
                    default:
                        r.read_data = ALL_ONES_BYTE;
                endcase
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void log_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
            $display("%t %s", $realtime, msg);
    endfunction

    // offer one item after a random gap, predict it once it transfers
    task automatic send_item(input op_t op, input logic [OffsetW-1:0] off,
                             input logic [DataW-1:0] dat);
        item_t it;
        int    gap;
        gap = src_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.op     = op;
        it.offset = off;
        it.data   = dat;
        in_bus.valid  <= 1'b1;
        in_bus.op     <= op;
        in_bus.offset <= off;
        in_bus.data   <= dat;
        do @(posedge clk); while (!in_bus.ready);
        exp_results.push_back(predict_timer(it));
        sent_cnt++;
    endtask

    // sender pauses until every result is back
    task automatic wait_results();
        in_bus.valid <= 1'b0;
        do @(posedge clk); while (exp_results.size() != 0);
    endtask

    // run one timer from a write through the first phase, or on to idle
    task automatic run_timer(input logic irq, input logic [1:0] sel,
                             input logic [DataW-1:0] dat, input int read_gap,
                             input bit to_idle);
        int n;
        n = 0;
        send_item(OP_WRITE, timer_offset(irq, sel), dat);
        while (tmr_phase == PH_FIRST || (to_idle && tmr_phase != PH_IDLE))
        begin
            n++;
            if (n % read_gap == 0)
                send_item(OP_READ, read_offset(n[0] ? RD_CNT_A : RD_CNT_B),
                          8'($urandom_range(0, 255)));
            else if (n % read_gap == read_gap / 2)
                send_item(OP_READ, read_offset(n[0] ? RD_FLAG_A : RD_FLAG_B),
                          8'($urandom_range(0, 255)));
            else
                send_item(OP_TICK, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
        end
    endtask

    // voice latch, reset line and its read-back
    task automatic test_voice_latch();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        send_item(OP_READ, read_offset(RD_VOICE), 8'h00);
        send_item(OP_WRITE, WR_VOICE, 8'h00);
        send_item(OP_READ, read_offset(RD_VOICE), 8'hFF);
        send_item(OP_WRITE, WR_VOICE, 8'hFF);
        send_item(OP_READ, read_offset(RD_VOICE), 8'h00);
        send_item(OP_WRITE, WR_VOICE, 8'h10);
        send_item(OP_READ, read_offset(RD_VOICE), 8'h00);
        send_item(OP_WRITE, WR_VOICE, 8'hEF);
        send_item(OP_READ, read_offset(RD_VOICE), 8'h00);
        wait_results();
    endtask

    // unused ops, unused write offsets and default read decode
    task automatic test_register_decode();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b1;
        send_item(OP_NONE, OFF_TOP, 8'hFF);
        send_item(OP_WRITE, OFF_EDGE, 8'hA5);
        send_item(OP_WRITE, OFF_SPARE_A, 8'hFF);
        send_item(OP_WRITE, OFF_SPARE_B, 8'h01);
        send_item(OP_WRITE, OFF_TOP, 8'h80);
        send_item(OP_READ, read_offset(RD_CNT_A), 8'h00);
        send_item(OP_READ, read_offset(RD_SPARE_0), 8'h00);
        send_item(OP_READ, read_offset(RD_SPARE_1), 8'h00);
        send_item(OP_READ, read_offset(RD_SPARE_3), 8'h00);
        send_item(OP_READ, OFF_TOP, 8'h00);
        send_item(OP_TICK, OFF_TOP, 8'hFF);
        wait_results();
    endtask

    // zero count expires on the next tick; restart keeps the flag
    task automatic test_zero_count_restart();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b0;
        send_item(OP_WRITE, timer_offset(1'b1, 2'd0), 8'h00);
        send_item(OP_TICK, 7'h00, 8'h00);
        send_item(OP_WRITE, timer_offset(1'b0, 2'd1), 8'h01);
        send_item(OP_READ, read_offset(RD_FLAG_A), 8'h00);
        send_item(OP_READ, read_offset(RD_FLAG_B), 8'h00);
        repeat (3) send_item(OP_TICK, 7'h00, 8'h00);
        send_item(OP_READ, read_offset(RD_CNT_B), 8'h00);
        wait_results();
    endtask

    // every prescale, one run through both phases, and the largest count
    task automatic test_prescale_runs();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b1;
        send_item(OP_WRITE, timer_offset(1'b1, 2'd3), 8'hFF);
        repeat (5) send_item(OP_TICK, 7'h00, 8'h00);
        send_item(OP_READ, read_offset(RD_CNT_A), 8'h00);
        run_timer(1'b1, 2'd0, 8'h03, 16, 1'b1);
        run_timer(1'b0, 2'd0, 8'h20, 37, 1'b0);
        run_timer(1'b1, 2'd1, 8'h02, 9, 1'b0);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b0;
        run_timer(1'b0, 2'd2, 8'h01, 21, 1'b0);
        wait_results();
    endtask

    // long hold on the result side while items keep coming
    task automatic test_backpressure();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        hold_len    = HOLD_CYCLES;
        send_item(OP_WRITE, timer_offset(1'b1, 2'd0), 8'd20);
        repeat (40)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(OP_READ, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
            else
                send_item(OP_TICK, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
        end
        wait_results();
    endtask

    // random timer sequences with reads, restarts and noise
    task automatic test_random_traffic();
        int               kind;
        int               steps;
        int               pick;
        int               cap;
        logic [1:0]       sel;
        logic             irq;
        logic [DataW-1:0] dat;
        bit               to_idle;
        op_t              op;
        while (sent_cnt < ITEM_COUNT)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                to_idle = ($urandom_range(0, 3) == 0) &&
                          (sent_cnt + IDLE_RUN_MARGIN < ITEM_COUNT);
                steps   = $urandom_range(1, 40);
                sel     = 2'($urandom_range(0, 3));
                irq     = 1'($urandom_range(0, 1));
                cap     = (sel == 2'd0) ? 63 : (sel == 2'd1) ? 7 : (sel == 2'd2) ? 1 : 0;
                if ($urandom_range(0, 1))
                    cap = cap >> 4;
                dat = 8'($urandom_range(0, cap));
                send_item(OP_WRITE, timer_offset(irq, sel), dat);
                while (to_idle ? (tmr_phase != PH_IDLE) : (steps > 0))
                begin
                    steps--;
                    pick = $urandom_range(0, 19);
                    if (pick < 12)
                        send_item(OP_TICK, 7'($urandom_range(0, 127)),
                                  8'($urandom_range(0, 255)));
                    else if (pick < 16)
                        send_item(OP_READ, 7'($urandom_range(0, 127)),
                                  8'($urandom_range(0, 255)));
                    else if (pick < 17)
                    begin
                        // noise that cannot touch the timer setup
                        case ($urandom_range(0, 2))
                            0:       op = OP_TICK;
                            1:       op = OP_READ;
                            default: op = OP_NONE;
                        endcase
                        send_item(op, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
                    end
                    else if (!to_idle && pick < 18)
                    begin
                        sel = 2'($urandom_range(0, 3));
                        dat = 8'($urandom_range(0, (sel == 2'd3) ? 1 : 7));
                        send_item(OP_WRITE, timer_offset(1'($urandom_range(0, 1)), sel), dat);
                    end
                    else if (!to_idle && pick < 19)
                        send_item(OP_WRITE, WR_VOICE, 8'($urandom_range(0, 255)));
                    else
                        send_item(OP_TICK, 7'($urandom_range(0, 127)),
                                  8'($urandom_range(0, 255)));
                end
            end
            else if (kind == 7)
            begin
                send_item(OP_WRITE, WR_VOICE, 8'($urandom_range(0, 255)));
                send_item(OP_READ, read_offset(RD_VOICE), 8'($urandom_range(0, 255)));
            end
            else if (kind == 8)
                send_item(op_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                          8'($urandom_range(0, 255)));
            else
            begin
                wait_results();
                src_idle_on = 1'($urandom_range(0, 1));
                snk_idle_on = 1'($urandom_range(0, 1));
            end
        end
    endtask

    // result side: random stalls per transfer, plus a long hold on request
    initial
    begin : result_sink
        int stall;
        out_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = snk_idle_on ? $urandom_range(0, 15) : 0;
            if (hold_len > 0)
            begin
                stall    = hold_len;
                hold_len = 0;
            end
            if (stall > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge clk); while (!out_bus.valid);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            got.read_data      = out_bus.read_data;
            got.irq_pulse      = out_bus.irq_pulse;
            got.reset_update   = out_bus.reset_update;
            got.reset_asserted = out_bus.reset_asserted;
            if (exp_results.size() == 0)
                log_error($sformatf("unexpected result read_data %02h irq %0b upd %0b asrt %0b",
                                    got.read_data, got.irq_pulse, got.reset_update,
                                    got.reset_asserted));
            else
            begin
                want = exp_results.pop_front();
                if (got.read_data !== want.read_data || got.irq_pulse !== want.irq_pulse ||
                    got.reset_update !== want.reset_update ||
                    got.reset_asserted !== want.reset_asserted)
                    log_error($sformatf({"mismatch read_data exp %02h got %02h, irq exp %0b ",
                                         "got %0b, upd exp %0b got %0b, asrt exp %0b got %0b"},
                                        want.read_data, got.read_data,
                                        want.irq_pulse, got.irq_pulse,
                                        want.reset_update, got.reset_update,
                                        want.reset_asserted, got.reset_asserted));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("riot_interval_timer_ports_unit_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        in_bus.valid  <= 1'b0;
        in_bus.op     <= OP_TICK;
        in_bus.offset <= '0;
        in_bus.data   <= '0;
        timer_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_voice_latch();
        test_register_decode();
        test_zero_count_restart();
        test_prescale_runs();
        test_backpressure();
        test_random_traffic();

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && exp_results.size() == 0)
            $display("riot_interval_timer_ports_unit_tb: PASS");
        else
            $display("riot_interval_timer_ports_unit_tb: FAIL");
        $finish;
    end

endmodule

### files.f
src/riot_pkg.sv
src/riot_if.sv
src/riot_timer_core.sv
src/riot_interval_timer_ports_unit.sv
verif/riot_interval_timer_ports_unit_tb.sv
